// ----- src/pxif_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG XMP iTXt framer package
// Shared constants, the CRC-32 byte step and the constant chunk head bytes.
// ----------------------------------------------------------------------------
package pxif_pkg;

	localparam logic [31:0] CrcPoly   = 32'hEDB88320;
	localparam logic [31:0] CrcPreset = 32'hFFFFFFFF;
	localparam logic [31:0] HeadExtra = 32'd22;

	localparam int unsigned PosWidth = 6;
	localparam logic [PosWidth-1:0] PosHeadFirst = 6'd0;
	localparam logic [PosWidth-1:0] PosType      = 6'd4;
	localparam logic [PosWidth-1:0] PosData      = 6'd30;
	localparam logic [PosWidth-1:0] PosCrcFirst  = 6'd31;
	localparam logic [PosWidth-1:0] PosCrcLast   = 6'd34;

	typedef struct packed {
		logic update;
		logic restart;
	} crc_ctl_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Type, keyword with its NUL, then the four zero bytes.
	function automatic logic [7:0] head_byte(input logic [PosWidth-1:0] pos);
		logic [7:0] b;
		unique case (pos)
			6'd4:    b = 8'h69;
			6'd5:    b = 8'h54;
			6'd6:    b = 8'h58;
			6'd7:    b = 8'h74;
			6'd8:    b = 8'h58;
			6'd9:    b = 8'h4D;
			6'd10:   b = 8'h4C;
			6'd11:   b = 8'h3A;
			6'd12:   b = 8'h63;
			6'd13:   b = 8'h6F;
			6'd14:   b = 8'h6D;
			6'd15:   b = 8'h2E;
			6'd16:   b = 8'h61;
			6'd17:   b = 8'h64;
			6'd18:   b = 8'h6F;
			6'd19:   b = 8'h62;
			6'd20:   b = 8'h65;
			6'd21:   b = 8'h2E;
			6'd22:   b = 8'h78;
			6'd23:   b = 8'h6D;
			6'd24:   b = 8'h70;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ----- src/pxif_crc.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG XMP iTXt framer CRC unit
// Running reflected CRC-32, advanced by one byte per update.
// ----------------------------------------------------------------------------
module pxif_crc
	import pxif_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire crc_ctl_t    ctl,
	input  wire logic [7:0]  data,
	output logic      [31:0] crc
);

	logic [31:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CrcPreset;
		end else if (ctl.update) begin
			crc_q <= crc_byte(ctl.restart ? CrcPreset : crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule
`default_nettype wire

// ----- src/png_xmp_itxt_chunk_framer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG XMP iTXt chunk framer
// The input channel takes one payload word per handshake; the payload length
// is sampled on the first word of each chunk. The output channel gives one
// byte of the framed chunk per handshake. The first word of a chunk produces
// the 30-byte chunk head and then its payload byte; the last word produces
// its payload byte and then the four CRC bytes. Other words give one byte.
// A word accepted at one edge has its first byte registered on the output at
// the next edge that the output is free. While the receiver does not stall,
// the output emits one byte per cycle. Mid-chunk words flow at one per cycle;
// a first word also holds the block for the head, a last word for the CRC.
// The next word is taken in the same cycle that the current word's final
// byte moves to the output register. When the receiver stalls, the output
// byte holds and the block stalls the input once its held word is pending.
// Reset empties the block, closes any open chunk and presets the CRC.
// ----------------------------------------------------------------------------
module png_xmp_itxt_chunk_framer_top
	import pxif_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [30:0] payload_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  out_byte,
	output logic             end_of_chunk,
	output logic             last_of_item
);

	logic                inside_q;
	logic [30:0]         rem_q;
	logic                hold_valid_q;
	logic [PosWidth-1:0] pos_q;
	logic [7:0]          data_s1;
	logic [31:0]         clen_s1;
	logic                closes_s1;

	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                end_q;
	logic                last_q;

	logic [30:0] plen_sat;
	logic [30:0] rem_next;
	logic        closes;
	logic        accept;
	logic        out_load;
	logic        emit;
	logic        item_last;
	logic [7:0]  emit_byte;
	logic [31:0] crc;
	logic [31:0] crc_fin;
	logic [1:0]  crc_sel;
	crc_ctl_t    crc_ctl;

	assign plen_sat = (payload_length == 31'd0) ? 31'd1 : payload_length;
	assign rem_next = (inside_q ? rem_q : plen_sat) - 31'd1;
	assign closes   = (rem_next == 31'd0);

	assign out_load  = !out_valid_q || !out_stall;
	assign emit      = hold_valid_q && out_load;
	assign item_last = ((pos_q == PosData) && !closes_s1) || (pos_q == PosCrcLast);
	assign in_stall  = hold_valid_q && !(emit && item_last);
	assign accept    = in_valid && !in_stall;

	assign crc_fin = crc ^ CrcPreset;
	assign crc_sel = 2'(pos_q - PosCrcFirst);

	always_comb begin
		priority if (pos_q < PosType) begin
			unique case (pos_q[1:0])
				2'd0:    emit_byte = clen_s1[31:24];
				2'd1:    emit_byte = clen_s1[23:16];
				2'd2:    emit_byte = clen_s1[15:8];
				default: emit_byte = clen_s1[7:0];
			endcase
		end else if (pos_q < PosData) begin
			emit_byte = head_byte(pos_q);
		end else if (pos_q == PosData) begin
			emit_byte = data_s1;
		end else begin
			unique case (crc_sel)
				2'd0:    emit_byte = crc_fin[31:24];
				2'd1:    emit_byte = crc_fin[23:16];
				2'd2:    emit_byte = crc_fin[15:8];
				default: emit_byte = crc_fin[7:0];
			endcase
		end
	end

	assign crc_ctl.update  = emit && (pos_q >= PosType) && (pos_q <= PosData);
	assign crc_ctl.restart = (pos_q == PosType);

	pxif_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (emit_byte),
		.crc    (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q     <= 1'b0;
			rem_q        <= 31'd0;
			hold_valid_q <= 1'b0;
			pos_q        <= PosHeadFirst;
		end else if (accept) begin
			inside_q     <= !closes;
			rem_q        <= rem_next;
			hold_valid_q <= 1'b1;
			pos_q        <= inside_q ? PosData : PosHeadFirst;
		end else if (emit) begin
			if (item_last) begin
				hold_valid_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1   <= data_byte;
			clen_s1   <= {1'b0, plen_sat} + HeadExtra;
			closes_s1 <= closes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			end_q      <= (pos_q == PosCrcLast);
			last_q     <= item_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign end_of_chunk = end_q;
	assign last_of_item = last_q;

endmodule
`default_nettype wire
